// ===== hdl/ktil_pkg.sv =====
// Shared types and constants for the keyed table insert/lookup block.
`default_nettype none
package ktil_pkg;

    // Default sizes of the table.
    localparam int DEF_TABLE_DEPTH  = 16;
    localparam int DEF_KEY_BYTES    = 6;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Fixed widths of the stream fields.
    localparam int KEY_FIELD_W   = 48;
    localparam int PAY_FIELD_W   = 32;
    localparam int COUNT_FIELD_W = 5;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 40;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_HIT    = 2'd2,
        ST_MISS   = 2'd3
    } t_status;

    // Control part of the query token that walks down the cell chain.
    typedef struct packed {
        logic active;
        t_op  op;
        logic hit;
        logic has_free;
    } t_tok_ctl;

endpackage
`default_nettype wire

// ===== hdl/ktil_cell.sv =====
// One table entry of the chain: holds key, payload and valid mark, forwards the query token.
`default_nettype none
module ktil_cell #(
    parameter int KEY_W    = 48,
    parameter int PAY_W    = 32,
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ktil_pkg::t_tok_ctl  i_ctl,
    input  wire logic [KEY_W-1:0]    i_key,
    input  wire logic [PAY_W-1:0]    i_pay,
    input  wire logic [IDX_W-1:0]    i_idx,
    output ktil_pkg::t_tok_ctl       o_ctl,
    output logic      [KEY_W-1:0]    o_key,
    output logic      [PAY_W-1:0]    o_pay,
    output logic      [IDX_W-1:0]    o_idx,
    input  wire logic                i_wr_en,
    input  wire logic [IDX_W-1:0]    i_wr_idx,
    input  wire logic [KEY_W-1:0]    i_wr_key,
    input  wire logic [PAY_W-1:0]    i_wr_pay
);

    logic               r_valid;
    logic [KEY_W-1:0]   r_key;
    logic [PAY_W-1:0]   r_pay;

    ktil_pkg::t_tok_ctl r_ctl;
    ktil_pkg::t_tok_ctl n_ctl;
    logic [KEY_W-1:0]   r_tok_key;
    logic [PAY_W-1:0]   r_tok_pay;
    logic [PAY_W-1:0]   n_tok_pay;
    logic [IDX_W-1:0]   r_tok_idx;
    logic [IDX_W-1:0]   n_tok_idx;

    logic w_match;
    logic w_upd;
    logic w_fill;

    // Stored contents only count behind a set valid mark.
    assign w_match = r_valid && (r_key == i_key);
    assign w_upd   = i_ctl.active && w_match && (i_ctl.op == ktil_pkg::OP_INSERT);
    assign w_fill  = i_wr_en && (i_wr_idx == IDX_W'(CELL_IDX));

    always_comb begin
        n_ctl     = i_ctl;
        n_tok_pay = i_pay;
        n_tok_idx = i_idx;
        if (w_match) begin
            n_ctl.hit = 1'b1;
            if (i_ctl.op == ktil_pkg::OP_LOOKUP) begin
                n_tok_pay = r_pay;
            end
        end
        // The first free entry along the chain is the lowest one.
        if (!r_valid && !i_ctl.has_free) begin
            n_ctl.has_free = 1'b1;
            n_tok_idx      = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ctl <= n_ctl;
            if (w_fill) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_key <= i_key;
        r_tok_pay <= n_tok_pay;
        r_tok_idx <= n_tok_idx;
        if (w_fill) begin
            r_key <= i_wr_key;
            r_pay <= i_wr_pay;
        end else if (w_upd) begin
            r_pay <= i_pay;
        end
    end

    assign o_ctl = r_ctl;
    assign o_key = r_tok_key;
    assign o_pay = r_tok_pay;
    assign o_idx = r_tok_idx;

endmodule
`default_nettype wire

// ===== hdl/keyed_table_insert_lookup.sv =====
// Top level of the keyed table: stream ports, cell chain, result staging and entry count.
//
// The table is a row of TABLE_DEPTH cells, one entry per cell. An accepted word
// becomes a query token that enters the first cell in the accept cycle and moves
// one cell per clock. On its way each cell compares its key, updates its payload
// on an insert hit, hands its payload into the token on a lookup hit, and the
// token remembers the lowest free entry it passes. When the token leaves the last
// cell the status is decided; an insert with no match and a free entry writes that
// entry through a one-cycle broadcast to all cells and raises the count. The result
// is held in a pending register and then in the output register that drives the
// master side; the next input word can be taken once the pending result has moved
// into the output register. Only one query is in the table at a time. A finished
// result waits in the output register so that the next query can start while it
// is held. Reset clears all valid marks and the count at once; no clearing pass is
// needed.
`default_nettype none
module keyed_table_insert_lookup #(
    parameter int TABLE_DEPTH  = ktil_pkg::DEF_TABLE_DEPTH,
    parameter int KEY_BYTES    = ktil_pkg::DEF_KEY_BYTES,
    parameter int PAYLOAD_BITS = ktil_pkg::DEF_PAYLOAD_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input stream.
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // From the lowest bit up: device_key[47:0], entry_payload[79:48].
    input  wire logic [ktil_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // opcode.
    input  wire logic                                i_s_axis_tuser,
    // Output stream.
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // From the lowest bit up: found_payload[31:0], entry_count[36:32], zero fill.
    output logic      [ktil_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // status.
    output logic      [1:0]                          o_m_axis_tuser
);

    // Only the low KEY_BYTES bytes of the key and the low PAYLOAD_BITS bits of
    // the payload take part; both are capped at the field widths.
    localparam int KEY_W   = (KEY_BYTES * 8 > ktil_pkg::KEY_FIELD_W) ?
                             ktil_pkg::KEY_FIELD_W : KEY_BYTES * 8;
    localparam int PAY_W   = (PAYLOAD_BITS > ktil_pkg::PAY_FIELD_W) ?
                             ktil_pkg::PAY_FIELD_W : PAYLOAD_BITS;
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_EXT = CNT_W + ktil_pkg::COUNT_FIELD_W;

    // Token links between the cells; entry k is the output of cell k.
    ktil_pkg::t_tok_ctl w_ctl [TABLE_DEPTH];
    logic [KEY_W-1:0]   w_key [TABLE_DEPTH];
    logic [PAY_W-1:0]   w_pay [TABLE_DEPTH];
    logic [IDX_W-1:0]   w_idx [TABLE_DEPTH];

    ktil_pkg::t_tok_ctl w_launch;
    logic [KEY_W-1:0]   w_in_key;
    logic [PAY_W-1:0]   w_in_pay;
    logic               w_in_acc;

    ktil_pkg::t_tok_ctl w_last;
    logic               w_done;
    logic               w_wr_en;

    // Control registers.
    logic               r_busy;
    logic               r_pend_vld;
    logic               r_out_vld;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // Result staging: pending result and output word.
    ktil_pkg::t_status  r_pend_status;
    ktil_pkg::t_status  n_pend_status;
    logic [ktil_pkg::PAY_FIELD_W-1:0]   r_pend_pay;
    logic [ktil_pkg::PAY_FIELD_W-1:0]   n_pend_pay;
    logic [ktil_pkg::COUNT_FIELD_W-1:0] r_pend_cnt;
    logic [CNT_EXT-1:0]                 w_cnt_ext;
    ktil_pkg::t_status                  r_out_status;
    logic [ktil_pkg::PAY_FIELD_W-1:0]   r_out_pay;
    logic [ktil_pkg::COUNT_FIELD_W-1:0] r_out_cnt;
    logic                               w_move;

    // One query in the table at a time.
    assign o_s_axis_tready = !r_busy;
    assign w_in_acc        = i_s_axis_tvalid && !r_busy;

    assign w_in_key = i_s_axis_tdata[KEY_W-1:0];
    assign w_in_pay = i_s_axis_tdata[ktil_pkg::KEY_FIELD_W +: PAY_W];

    always_comb begin
        w_launch          = '0;
        w_launch.active   = w_in_acc;
        w_launch.op       = ktil_pkg::t_op'(i_s_axis_tuser);
    end

    // The cell chain.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            ktil_cell #(
                .KEY_W    (KEY_W),
                .PAY_W    (PAY_W),
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_launch),
                .i_key    (w_in_key),
                .i_pay    (w_in_pay),
                .i_idx    ('0),
                .o_ctl    (w_ctl[g]),
                .o_key    (w_key[g]),
                .o_pay    (w_pay[g]),
                .o_idx    (w_idx[g]),
                .i_wr_en  (w_wr_en),
                .i_wr_idx (w_idx[TABLE_DEPTH-1]),
                .i_wr_key (w_key[TABLE_DEPTH-1]),
                .i_wr_pay (w_pay[TABLE_DEPTH-1])
            );
        end else begin : g_body
            ktil_cell #(
                .KEY_W    (KEY_W),
                .PAY_W    (PAY_W),
                .IDX_W    (IDX_W),
                .CELL_IDX (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl[g-1]),
                .i_key    (w_key[g-1]),
                .i_pay    (w_pay[g-1]),
                .i_idx    (w_idx[g-1]),
                .o_ctl    (w_ctl[g]),
                .o_key    (w_key[g]),
                .o_pay    (w_pay[g]),
                .o_idx    (w_idx[g]),
                .i_wr_en  (w_wr_en),
                .i_wr_idx (w_idx[TABLE_DEPTH-1]),
                .i_wr_key (w_key[TABLE_DEPTH-1]),
                .i_wr_pay (w_pay[TABLE_DEPTH-1])
            );
        end
    end

    // The token has passed every entry: decide the outcome.
    assign w_last = w_ctl[TABLE_DEPTH-1];
    assign w_done = w_last.active;

    // A new entry is written only for an unmatched insert that found room. The
    // token still carries the insert key and payload for that broadcast write.
    assign w_wr_en = w_done && (w_last.op == ktil_pkg::OP_INSERT) &&
                     !w_last.hit && w_last.has_free;

    always_comb begin
        n_count       = r_count + CNT_W'(w_wr_en);
        n_pend_pay    = '0;
        n_pend_status = ktil_pkg::ST_MISS;
        if (w_last.op == ktil_pkg::OP_INSERT) begin
            if (w_last.hit || w_last.has_free) begin
                n_pend_status = ktil_pkg::ST_STORED;
            end else begin
                n_pend_status = ktil_pkg::ST_FULL;
            end
        end else if (w_last.hit) begin
            n_pend_status = ktil_pkg::ST_HIT;
            n_pend_pay    = ktil_pkg::PAY_FIELD_W'(w_pay[TABLE_DEPTH-1]);
        end
    end

    // The reported count is the count taken modulo 2**COUNT_FIELD_W.
    assign w_cnt_ext = CNT_EXT'(n_count);

    // The pending result moves out once the output register is free or its word is being taken.
    assign w_move = r_pend_vld && (!r_out_vld || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_count    <= '0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_done) begin
                r_pend_vld <= 1'b1;
                r_count    <= n_count;
            end else if (w_move) begin
                r_pend_vld <= 1'b0;
            end
            if (w_move) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_pend_status <= n_pend_status;
            r_pend_pay    <= n_pend_pay;
            r_pend_cnt    <= w_cnt_ext[ktil_pkg::COUNT_FIELD_W-1:0];
        end
        if (w_move) begin
            r_out_status <= r_pend_status;
            r_out_pay    <= r_pend_pay;
            r_out_cnt    <= r_pend_cnt;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = ktil_pkg::OUT_TDATA_W'({r_out_cnt, r_out_pay});

endmodule
`default_nettype wire
